// ===== rtl/ssfm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssfm_pkg
// Shared constants, model tables and control types of the structured symbol
// frequency model.
// ----------------------------------------------------------------------------
package ssfm_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int NUM_MODELS      = 8;
	localparam int POOL_SIZE       = 264;
	localparam int POOL_AW         = 9;
	localparam int MODEL_W         = 3;
	localparam int IDX_W           = 7;
	localparam int SYM_W           = 9;
	localparam int DATA_W          = 16;
	localparam int INCR_W          = 4;
	localparam int INIT_W          = 8;
	localparam int CFG_W           = 32;
	localparam int PADDR_W         = 3;

	localparam logic [SYM_W-1:0]  SYM_MAX        = 9'd256;
	localparam logic [SYM_W-1:0]  SYM_LAST_PLAIN = 9'd2;
	localparam logic [DATA_W-1:0] THRESH_RESET   = 16'hFFFF;
	localparam logic              REG_THRESHOLD  = 1'b0;
	localparam logic [MODEL_W-1:0] CLASS_MODEL   = 3'd0;

	typedef struct packed {
		logic clear;
		logic start;
		logic sum;
		logic emit;
		logic update;
		logic half;
		logic next;
	} ssfm_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic sum_hit;
		logic out_free;
		logic need_half;
		logic half_last;
		logic more;
	} ssfm_sts_t;

	function automatic logic [POOL_AW-1:0] model_base(input logic [MODEL_W-1:0] m);
		case (m)
			3'd0: return 9'd0;
			3'd1: return 9'd10;
			3'd2: return 9'd12;
			3'd3: return 9'd16;
			3'd4: return 9'd24;
			3'd5: return 9'd40;
			3'd6: return 9'd72;
			3'd7: return 9'd136;
			default: return 9'd0;
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] model_nent_m1(input logic [MODEL_W-1:0] m);
		case (m)
			3'd0: return 7'd9;
			3'd1: return 7'd1;
			3'd2: return 7'd3;
			3'd3: return 7'd7;
			3'd4: return 7'd15;
			3'd5: return 7'd31;
			3'd6: return 7'd63;
			3'd7: return 7'd127;
			default: return 7'd0;
		endcase
	endfunction

	function automatic logic [INCR_W-1:0] model_incr(input logic [MODEL_W-1:0] m);
		case (m)
			3'd0: return 4'd12;
			3'd1: return 4'd4;
			3'd2: return 4'd3;
			3'd3: return 4'd3;
			3'd4: return 4'd3;
			3'd5: return 4'd3;
			3'd6: return 4'd2;
			3'd7: return 4'd1;
			default: return 4'd1;
		endcase
	endfunction

	function automatic logic [INIT_W-1:0] model_init_total(input logic [MODEL_W-1:0] m);
		case (m)
			3'd0: return 8'd120;
			3'd1: return 8'd8;
			3'd2: return 8'd12;
			3'd3: return 8'd24;
			3'd4: return 8'd48;
			3'd5: return 8'd96;
			3'd6: return 8'd128;
			3'd7: return 8'd128;
			default: return 8'd0;
		endcase
	endfunction

	function automatic logic [INCR_W-1:0] pool_incr(input logic [POOL_AW-1:0] addr);
		logic [INCR_W-1:0] r;
		r = model_incr(CLASS_MODEL);
		for (int k = 1; k < NUM_MODELS; k++) begin
			if (addr >= model_base(MODEL_W'(k))) begin
				r = model_incr(MODEL_W'(k));
			end
		end
		return r;
	endfunction

	function automatic logic [MODEL_W-1:0] top_bit(input logic [7:0] v);
		logic [MODEL_W-1:0] r;
		r = 3'd1;
		for (int k = 2; k < 8; k++) begin
			if (v[k]) begin
				r = MODEL_W'(k);
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/ssfm_ram.sv =====
// ----------------------------------------------------------------------------
// ssfm_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module ssfm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 264
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/ssfm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssfm_ctrl
// Sequencer: table init, cumulative walk, result hand-off, update and halving.
// ----------------------------------------------------------------------------
module ssfm_ctrl import ssfm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  ssfm_sts_t sts,
	output ssfm_cmd_t cmd
);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_SUM   = 7'b0000100,
		S_EMIT  = 7'b0001000,
		S_UPD   = 7'b0010000,
		S_HALF  = 7'b0100000,
		S_MOVE  = 7'b1000000
	} ssfm_state_t;

	ssfm_state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_SUM;
				end
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				if (sts.sum_hit) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_UPD;
				end
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_d    = sts.need_half ? S_HALF : S_MOVE;
			end
			S_HALF: begin
				cmd.half = 1'b1;
				if (sts.half_last) begin
					state_d = S_MOVE;
				end
			end
			S_MOVE: begin
				if (sts.more) begin
					cmd.next = 1'b1;
					state_d  = S_SUM;
				end else begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

// ===== rtl/ssfm_datapath.sv =====
// ----------------------------------------------------------------------------
// ssfm_datapath
// Symbol decode, count memory, model totals, running sums and result register.
// ----------------------------------------------------------------------------
module ssfm_datapath import ssfm_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ssfm_cmd_t         cmd,
	output ssfm_sts_t         sts,
	input  logic [SYM_W-1:0]  symbol,
	input  logic [DATA_W-1:0] threshold,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [DATA_W-1:0] cum_start,
	output logic [DATA_W-1:0] freq,
	output logic [DATA_W-1:0] total,
	output logic              last
);

	localparam int TW = COUNT_WIDTH + 1;
	localparam logic [DATA_W-1:0] CAP = DATA_W'((1 << COUNT_WIDTH) - 1);

	logic [MODEL_W-1:0]     m_q, bkt_q;
	logic [IDX_W-1:0]       idx_q, sub_q, rd_i_q, pidx_s1;
	logic                   pend_s1;
	logic [TW-1:0]          acc_q, cnt_new_q;
	logic [COUNT_WIDTH-1:0] freq_q;
	logic [POOL_AW-1:0]     clr_addr_q;
	logic [TW-1:0]          totals_q [NUM_MODELS];
	logic                   out_valid_q, last_q;
	logic [DATA_W-1:0]      cum_start_q, freq_out_q, total_q;

	logic [POOL_AW-1:0]     base, raddr, waddr;
	logic [IDX_W-1:0]       nent_m1;
	logic [INCR_W-1:0]      incr;
	logic [DATA_W-1:0]      limit;
	logic [TW-1:0]          tot_new, cnt_new, half_src, half_val, half_tot, acc_sum;
	logic                   need_half, we;
	logic [COUNT_WIDTH-1:0] wdata, rdata;

	logic [SYM_W-1:0]   sym_sat;
	logic [7:0]         v;
	logic [MODEL_W-1:0] dec_b;
	logic [IDX_W-1:0]   dec_cls, dec_sub;

	assign sym_sat = (symbol > SYM_MAX) ? SYM_MAX : symbol;
	assign v       = 8'(sym_sat - 9'd1);

	always_comb begin
		dec_b   = '0;
		dec_cls = IDX_W'(sym_sat);
		dec_sub = '0;
		if (sym_sat > SYM_LAST_PLAIN) begin
			dec_b   = top_bit(v);
			dec_cls = IDX_W'(dec_b) + IDX_W'(2);
			dec_sub = IDX_W'(v & ~(8'd1 << dec_b));
		end
	end

	assign base     = model_base(m_q);
	assign nent_m1  = model_nent_m1(m_q);
	assign incr     = model_incr(m_q);
	assign limit    = (threshold > CAP) ? CAP : threshold;
	assign tot_new  = totals_q[m_q] + TW'(incr);
	assign cnt_new  = TW'(freq_q) + TW'(incr);
	assign need_half = (tot_new >= TW'(limit));
	assign half_src = (pidx_s1 == idx_q) ? cnt_new_q : TW'(rdata);
	assign half_val = (half_src + TW'(1)) >> 1;
	assign half_tot = acc_q + half_val;
	assign acc_sum  = acc_q + TW'(rdata);
	assign raddr    = base + POOL_AW'(rd_i_q);

	always_comb begin
		we    = 1'b0;
		waddr = clr_addr_q;
		wdata = COUNT_WIDTH'(pool_incr(clr_addr_q));
		if (cmd.clear) begin
			we = 1'b1;
		end else if (cmd.update && !need_half) begin
			we    = 1'b1;
			waddr = base + POOL_AW'(idx_q);
			wdata = cnt_new[COUNT_WIDTH-1:0];
		end else if (cmd.half && pend_s1) begin
			we    = 1'b1;
			waddr = base + POOL_AW'(pidx_s1);
			wdata = half_val[COUNT_WIDTH-1:0];
		end
	end

	ssfm_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(POOL_SIZE)
	) u_pool (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			clr_addr_q  <= '0;
			for (int k = 0; k < NUM_MODELS; k++) begin
				totals_q[k] <= TW'(model_init_total(MODEL_W'(k)));
			end
		end else begin
			if (cmd.start || cmd.next || cmd.update) begin
				pend_s1 <= 1'b0;
			end else if (cmd.sum || cmd.half) begin
				pend_s1 <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.clear) begin
				clr_addr_q <= clr_addr_q + POOL_AW'(1);
			end
			if (cmd.update) begin
				totals_q[m_q] <= tot_new;
			end else if (cmd.half && sts.half_last) begin
				totals_q[m_q] <= half_tot;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			m_q   <= CLASS_MODEL;
			idx_q <= dec_cls;
			bkt_q <= dec_b;
			sub_q <= dec_sub;
		end else if (cmd.next) begin
			m_q   <= bkt_q;
			idx_q <= sub_q;
		end
		if (cmd.start || cmd.next || cmd.update) begin
			rd_i_q <= '0;
			acc_q  <= '0;
		end else if (cmd.sum) begin
			if (rd_i_q != idx_q) begin
				rd_i_q <= rd_i_q + IDX_W'(1);
			end
			if (pend_s1 && (pidx_s1 != idx_q)) begin
				acc_q <= acc_sum;
			end
		end else if (cmd.half) begin
			if (rd_i_q != nent_m1) begin
				rd_i_q <= rd_i_q + IDX_W'(1);
			end
			if (pend_s1) begin
				acc_q <= half_tot;
			end
		end
		if (cmd.sum || cmd.half) begin
			pidx_s1 <= rd_i_q;
		end
		if (cmd.sum && sts.sum_hit) begin
			freq_q <= rdata;
		end
		if (cmd.update) begin
			cnt_new_q <= cnt_new;
		end
		if (cmd.emit) begin
			cum_start_q <= DATA_W'(acc_q[COUNT_WIDTH-1:0]);
			freq_out_q  <= DATA_W'(freq_q);
			total_q     <= DATA_W'(totals_q[m_q][COUNT_WIDTH-1:0]);
			last_q      <= (m_q != CLASS_MODEL) || (bkt_q == CLASS_MODEL);
		end
	end

	assign sts.clear_last = (clr_addr_q == POOL_AW'(POOL_SIZE - 1));
	assign sts.sum_hit    = pend_s1 && (pidx_s1 == idx_q);
	assign sts.out_free   = !out_valid_q || !out_stall;
	assign sts.need_half  = need_half;
	assign sts.half_last  = pend_s1 && (pidx_s1 == nent_m1);
	assign sts.more       = (m_q == CLASS_MODEL) && (bkt_q != CLASS_MODEL);

	assign out_valid = out_valid_q;
	assign cum_start = cum_start_q;
	assign freq      = freq_out_q;
	assign total     = total_q;
	assign last      = last_q;

`ifndef NO_ASSERTIONS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid_q && out_stall))
		else $error("result register overwritten while stalled");

	a_freq_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (freq_q != '0))
		else $error("coded count is zero");

	a_total_fits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (totals_q[m_q][COUNT_WIDTH] == 1'b0))
		else $error("model total exceeds count width");

	a_cum_below_total: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sum && sts.sum_hit) |-> (acc_q < totals_q[m_q]))
		else $error("cumulative start not below model total");
`endif

endmodule

// ===== rtl/structured_symbol_freq_model_unit.sv =====
// ----------------------------------------------------------------------------
// structured_symbol_freq_model_unit
// Adaptive structured frequency model producing range-coder triples.
// ----------------------------------------------------------------------------
// Symbols enter on in_valid/in_stall; an item is taken when in_valid is high
// and in_stall is low. Each symbol yields one triple (cum_start, freq, total)
// from the class model, and bucket symbols a second triple from the bucket
// model; last marks the final triple of a symbol. Results leave on
// out_valid/out_stall from a result register.
// The count memory is walked one entry per cycle through its single read
// port; a halving pass walks every entry of the model. One symbol is
// handled at a time. After reset the block loads the initial counts with
// in_stall high; rescale_threshold resets to 65535 and may be written over
// the APB port while the block is idle. When the receiver stalls, the result
// waits in its register and the block holds in front of its next result.
module structured_symbol_freq_model_unit import ssfm_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [SYM_W-1:0]   symbol,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [DATA_W-1:0]  cum_start,
	output logic [DATA_W-1:0]  freq,
	output logic [DATA_W-1:0]  total,
	output logic               last,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [CFG_W-1:0]   pwdata,
	output logic [CFG_W-1:0]   prdata,
	output logic               pready
);

	logic [DATA_W-1:0] threshold_q;
	logic              reg_sel;
	ssfm_cmd_t         cmd;
	ssfm_sts_t         sts;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_THRESHOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESH_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			threshold_q <= pwdata[DATA_W-1:0];
		end
	end

	assign prdata = reg_sel ? CFG_W'(threshold_q) : '0;

	ssfm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	ssfm_datapath #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.symbol   (symbol),
		.threshold(threshold_q),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.cum_start(cum_start),
		.freq     (freq),
		.total    (total),
		.last     (last)
	);

endmodule

// ===== test/structured_symbol_freq_model_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// structured_symbol_freq_model_unit_tb
// Self-checking bench for the structured symbol frequency model. A scoreboard
// class keeps its own copy of the class and bucket counts, predicts every
// range-coder triple from the accepted symbols and checks the results in
// order. Symbols come as a directed corner set followed by random phases under
// several rescale thresholds, with random idling on both sides, a long
// receiver hold-off and a sender pause.
// ----------------------------------------------------------------------------
module structured_symbol_freq_model_unit_tb;
	import ssfm_pkg::*;

	localparam logic [PADDR_W-1:0] THRESH_ADDR = PADDR_W'(4 * REG_THRESHOLD);
	localparam int SETTLE_CYCLES = 300;
	localparam int HOLD_CYCLES   = 800;

	class freq_scoreboard;
		typedef struct packed {
			logic [DATA_W-1:0] cum_start;
			logic [DATA_W-1:0] freq;
			logic [DATA_W-1:0] total;
			logic              last;
		} triple_t;

		int unsigned counts[POOL_SIZE];
		int unsigned totals[NUM_MODELS];
		int unsigned base_of[NUM_MODELS];
		int unsigned size_of[NUM_MODELS];
		int unsigned step_of[NUM_MODELS];
		logic [DATA_W-1:0] threshold;
		triple_t expected_triples[$];
		int errors;

		function new();
			base_of = '{0, 10, 12, 16, 24, 40, 72, 136};
			size_of = '{10, 2, 4, 8, 16, 32, 64, 128};
			step_of = '{12, 4, 3, 3, 3, 3, 2, 1};
			for (int m = 0; m < NUM_MODELS; m++) begin
				for (int i = 0; i < size_of[m]; i++) begin
					counts[base_of[m] + i] = step_of[m];
				end
				totals[m] = step_of[m] * size_of[m];
			end
			threshold = THRESH_RESET;
			errors = 0;
		endfunction

		function void set_threshold(input logic [DATA_W-1:0] v);
			threshold = v;
		endfunction

		function void code_entry(input int m, input int idx, input logic fin);
			int unsigned start;
			int unsigned sum;
			int unsigned c;
			triple_t t;
			start = 0;
			for (int i = 0; i < idx; i++) begin
				start += counts[base_of[m] + i];
			end
			t.cum_start = start[DATA_W-1:0];
			t.freq = counts[base_of[m] + idx][DATA_W-1:0];
			t.total = totals[m][DATA_W-1:0];
			t.last = fin;
			expected_triples.push_back(t);
			totals[m] += step_of[m];
			counts[base_of[m] + idx] += step_of[m];
			if (totals[m] >= threshold) begin
				sum = 0;
				for (int i = 0; i < size_of[m]; i++) begin
					c = (counts[base_of[m] + i] + 1) >> 1;
					counts[base_of[m] + i] = c;
					sum += c;
				end
				totals[m] = sum;
			end
		endfunction

		function void note_symbol(input logic [SYM_W-1:0] sym);
			logic [SYM_W-1:0] s;
			logic [7:0] v;
			int b;
			s = (sym > SYM_MAX) ? SYM_MAX : sym;
			if (s <= SYM_LAST_PLAIN) begin
				code_entry(CLASS_MODEL, int'(s), 1'b1);
			end else begin
				v = 8'(s - 1);
				b = 7;
				while (b > 1 && !v[b]) b--;
				code_entry(CLASS_MODEL, 2 + b, 1'b0);
				code_entry(b, int'(v) - (1 << b), 1'b1);
			end
		endfunction

		function void check_triple(input logic [DATA_W-1:0] cs, input logic [DATA_W-1:0] fq,
				input logic [DATA_W-1:0] tt, input logic lt);
			triple_t t;
			if (expected_triples.size() == 0) begin
				$error("unexpected result: cum_start %0d freq %0d total %0d last %0d",
					cs, fq, tt, lt);
				errors++;
				return;
			end
			t = expected_triples.pop_front();
			if (cs !== t.cum_start) begin
				$error("cum_start mismatch: expected %0d, actual %0d", t.cum_start, cs);
				errors++;
			end
			if (fq !== t.freq) begin
				$error("freq mismatch: expected %0d, actual %0d", t.freq, fq);
				errors++;
			end
			if (tt !== t.total) begin
				$error("total mismatch: expected %0d, actual %0d", t.total, tt);
				errors++;
			end
			if (lt !== t.last) begin
				$error("last mismatch: expected %0d, actual %0d", t.last, lt);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [SYM_W-1:0]   symbol;
	logic               out_valid;
	logic               out_stall;
	logic [DATA_W-1:0]  cum_start;
	logic [DATA_W-1:0]  freq;
	logic [DATA_W-1:0]  total;
	logic               last;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [CFG_W-1:0]   pwdata;
	logic [CFG_W-1:0]   prdata;
	logic               pready;

	freq_scoreboard sb = new();
	bit hold_request = 1'b0;
	bit quiet = 1'b0;

	logic [SYM_W-1:0] corner_syms[27] = '{
		9'd0, 9'd1, 9'd2, 9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9,
		9'd15, 9'd16, 9'd17, 9'd31, 9'd32, 9'd33, 9'd63, 9'd64, 9'd65,
		9'd127, 9'd128, 9'd129, 9'd255, 9'd256, 9'd257, 9'd511, 9'd300
	};

	structured_symbol_freq_model_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.symbol    (symbol),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cum_start (cum_start),
		.freq      (freq),
		.total     (total),
		.last      (last),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #4 clk = ~clk;

	task automatic send_symbol(input logic [SYM_W-1:0] s);
		while (!quiet && $urandom_range(0, 99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		symbol <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_symbol(s);
	endtask

	task automatic wait_drained();
		while (sb.expected_triples.size() != 0) @(posedge clk);
	endtask

	task automatic retune(input logic [DATA_W-1:0] v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= THRESH_ADDR;
		pwdata <= {16'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_threshold(v);
	endtask

	function automatic logic [SYM_W-1:0] pick_symbol(input logic [SYM_W-1:0] prev);
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) return prev;
		if (r < 55) return SYM_W'($urandom_range(0, 15));
		if (r < 75) return SYM_W'($urandom_range(16, 128));
		if (r < 90) return SYM_W'($urandom_range(129, 256));
		return SYM_W'($urandom_range(257, 511));
	endfunction

	task automatic run_random(input int n_items, input int hold_at, input int pause_at);
		logic [SYM_W-1:0] prev;
		prev = SYM_W'($urandom_range(0, 511));
		for (int k = 0; k < n_items; k++) begin
			if (k == hold_at) hold_request = 1'b1;
			if (k == pause_at) begin
				in_valid <= 1'b0;
				@(posedge clk);
				wait_drained();
			end
			prev = pick_symbol(prev);
			send_symbol(prev);
		end
		in_valid <= 1'b0;
	endtask

	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) sb.check_triple(cum_start, freq, total, last);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet && ($urandom_range(0, 99) < 11);
			end
		end
	end

	initial begin : watchdog
		#30000000;
		$display("structured_symbol_freq_model_unit verification failed");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		symbol = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		retune(THRESH_RESET);
		foreach (corner_syms[i]) send_symbol(corner_syms[i]);
		in_valid <= 1'b0;

		retune(16'd16);
		run_random(200, 40, -1);

		retune(16'($urandom_range(16, 400)));
		run_random(300, -1, 150);

		retune(THRESH_RESET);
		quiet = 1'b1;
		run_random(350, -1, -1);
		quiet = 1'b0;

		retune(16'($urandom_range(16, 65535)));
		run_random(300, 100, 200);

		retune(16'($urandom_range(100, 2000)));
		run_random(400, -1, -1);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("structured_symbol_freq_model_unit verification clean");
		end else begin
			$display("structured_symbol_freq_model_unit verification failed");
		end
		$finish;
	end

endmodule
